// ----- src/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
// Used by skt_cell and sorted_key_table; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int SLOT_W   = 5;
    localparam int STAT_W   = 2;
    localparam int CMD_W    = 2;
    localparam int IN_DATA_W  = KEY_W + PAY_W;
    localparam int OUT_RAW_W  = SLOT_W + KEY_W + PAY_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_USER_W = STAT_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_SCAN   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctl_t;

endpackage : skt_pkg

`default_nettype wire

// ----- src/skt_cell.sv -----
// One slot of the sorted table: holds an entry, compares it with the probe key
// and takes data from a neighbour on insert or scan rotation. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell
    import skt_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      valid,       // slot lies below the fill count
    input  wire logic      prev_lt,     // lower neighbour holds a smaller key
    input  wire entry_t    prev_entry,
    input  wire logic      next_valid,
    input  wire entry_t    next_entry,
    input  wire entry_t    head_entry,
    output entry_t         entry,
    output logic           lt,
    output logic           eq
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign lt    = valid && (entry_reg.key < ctl.item.key);
    assign eq    = valid && (entry_reg.key == ctl.item.key);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // below the insertion point: hold; at it: store; above: move up
                if (prev_lt && !lt)
                begin
                    entry_next = ctl.item;
                end
                else if (!prev_lt)
                begin
                    entry_next = prev_entry;
                end
            end
            CELL_ROTATE:
            begin
                // the top valid slot wraps round to the head
                if (next_valid)
                begin
                    entry_next = next_entry;
                end
                else if (valid)
                begin
                    entry_next = head_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : skt_cell

`default_nettype wire

// ----- src/sorted_key_table.sv -----
// Top level of the sorted key table: chain of skt_cell slots, command control
// and the output register. Uses skt_pkg and skt_cell.
`timescale 1ns / 1ps
`default_nettype none

// Sorted key table: a leaf of up to CAPACITY entries (32-bit key, 64-bit payload)
// held one per cell in a chain, kept in ascending key order with unique keys.
// Every cell compares its key with the probe key at once, so an insert or a find
// gives one result transaction; a new command is taken as soon as the output
// register is free and no scan is running. An insert moves every larger entry up
// one cell as the command is taken. A scan emits one result per stored entry, one
// per cycle while the output is taken, by rotating the chain towards cell 0 (after
// the last result the order is as before); an empty table gives one result with
// status 3. Command code 3 is accepted and ignored. There is no clearing pass.
module sorted_key_table
    import skt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // key [31:0], payload [95:32]
    input  wire logic [CMD_W-1:0]      s_tuser,   // cmd [1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // slot [4:0], out_key [36:5],
                                                  // out_payload [100:37], zero pad
    output logic [OUT_USER_W-1:0]      m_tuser,   // status [1:0], found [2]
    output logic                       m_tlast
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [STAT_W-1:0]     status_reg;
    logic [STAT_W-1:0]     status_next;
    logic                  found_reg;
    logic                  found_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    entry_t                res_reg;
    entry_t                res_next;
    logic                  last_reg;
    logic                  last_next;

    cell_ctl_t             ctl;
    cell_op_t              cell_op;
    entry_t                entries [CAPACITY];
    logic [CAPACITY-1:0]   lt;
    logic [CAPACITY-1:0]   eq;
    logic [CAPACITY-1:0]   valid;
    logic [CAPACITY-1:0]   boundary;

    cmd_t             cmd;
    entry_t           in_item;
    logic             out_free;
    logic             in_fire;
    logic             hit;
    logic             full;
    logic [CNT_W-1:0] pos;
    entry_t           hit_entry;
    logic             scan_last;
    logic             load_out;

    assign cmd          = cmd_t'(s_tuser);
    assign in_item.key     = s_tdata[KEY_W-1:0];
    assign in_item.payload = s_tdata[IN_DATA_W-1:KEY_W];
    assign out_free     = !m_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign in_fire      = s_tvalid && s_tready;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign scan_last    = ((idx_reg + CNT_W'(1)) == count_reg);
    assign ctl          = {cell_op, in_item};

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   prev_lt;
        entry_t prev_entry;
        logic   next_valid;
        entry_t next_entry;

        assign valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_lt    = 1'b1;
            assign prev_entry = '0;
        end
        else
        begin : g_inner
            assign prev_lt    = lt[i-1];
            assign prev_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign next_valid = 1'b0;
            assign next_entry = '0;
        end
        else
        begin : g_below
            assign next_valid = valid[i+1];
            assign next_entry = entries[i+1];
        end

        assign boundary[i] = prev_lt && !lt[i];

        skt_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid      (valid[i]),
            .prev_lt    (prev_lt),
            .prev_entry (prev_entry),
            .next_valid (next_valid),
            .next_entry (next_entry),
            .head_entry (entries[0]),
            .entry      (entries[i]),
            .lt         (lt[i]),
            .eq         (eq[i])
        );
    end

    // insertion point and matching entry, both from one-hot cell flags
    always_comb
    begin
        pos       = (boundary == '0) ? CNT_W'(CAPACITY) : '0;
        hit_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (boundary[i])
            begin
                pos = pos | CNT_W'(i);
            end
            if (eq[i])
            begin
                hit_entry = hit_entry | entries[i];
            end
        end
    end

    assign hit = |eq;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && cmd == CMD_SCAN && count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free && scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the control: cell command and result values
    always_comb
    begin
        cell_op     = CELL_HOLD;
        count_next  = count_reg;
        idx_next    = idx_reg;
        load_out    = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        res_next    = res_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                last_next = 1'b1;
                if (in_fire)
                begin
                    case (cmd)
                        CMD_INSERT:
                        begin
                            load_out   = 1'b1;
                            slot_next  = SLOT_W'(pos);
                            found_next = hit;
                            if (hit)
                            begin
                                status_next = STAT_DUP;
                                res_next    = hit_entry;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                                res_next    = '0;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                res_next    = in_item;
                                cell_op     = CELL_INSERT;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            load_out    = 1'b1;
                            status_next = STAT_OK;
                            found_next  = hit;
                            slot_next   = SLOT_W'(pos);
                            res_next    = hit_entry;
                        end
                        CMD_SCAN:
                        begin
                            // a non-empty table is walked in the scan state
                            if (count_reg == '0)
                            begin
                                load_out    = 1'b1;
                                status_next = STAT_EMPTY;
                                found_next  = 1'b0;
                                slot_next   = '0;
                                res_next    = '0;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    slot_next   = SLOT_W'(idx_reg);
                    res_next    = entries[0];
                    last_next   = scan_last;
                    cell_op     = CELL_ROTATE;
                    idx_next    = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            slot_reg   <= slot_next;
            res_reg    <= res_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({res_reg.payload, res_reg.key, slot_reg});
    assign m_tuser  = {found_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule : sorted_key_table

`default_nettype wire

// ----- sim/sorted_key_table_tb.sv -----
// Self-checking testbench for sorted_key_table: directed table then random traffic,
// every result compared against a fixed expectation or a behavioural copy of the table.
// Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 1ps

module sorted_key_table_tb;

    import skt_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 152;

    typedef struct packed {
        status_t         status;
        logic            found;
        logic [4:0]      slot;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic            last;
    } result_t;

    typedef struct {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        bit               known;
        result_t          res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = CMD_NONE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    // behavioural copy of the table
    logic [KEY_W-1:0] tbl_keys [CAPACITY];
    logic [PAY_W-1:0] tbl_pays [CAPACITY];
    int               tbl_count = 0;

    result_t   step_res [$];
    result_t   expected_q [$];
    stim_row_t rows [$];

    int  mismatches  = 0;
    int  unexpected  = 0;
    int  reports     = 0;
    int  checked     = 0;
    int  n_items     = 0;
    int  n_scans     = 0;
    int  n_ignored   = 0;
    int  idle_cycles = 0;
    bit  hold_req    = 1'b0;
    bit  hold_done   = 1'b0;

    sorted_key_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic result_t mk(status_t st, logic fnd, int slot, logic [KEY_W-1:0] k,
                                   logic [PAY_W-1:0] p, logic lst);
        result_t r;
        r.status  = st;
        r.found   = fnd;
        r.slot    = 5'(slot);
        r.key     = k;
        r.payload = p;
        r.last    = lst;
        return r;
    endfunction

    // binary search over the stored keys; lower bound on a miss
    function automatic int key_position(logic [KEY_W-1:0] k, output bit hit);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = tbl_count;
        hit = 1'b0;
        while (lo != hi)
        begin
            mid = (lo + hi) / 2;
            if (tbl_keys[mid] == k)
            begin
                hit = 1'b1;
                return mid;
            end
            if (k < tbl_keys[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    task automatic table_step(input cmd_t c, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p);
        int pos;
        bit hit;
        step_res.delete();
        case (c)
            CMD_INSERT:
            begin
                pos = key_position(k, hit);
                if (hit)
                    step_res.push_back(mk(STAT_DUP, 1'b1, pos, tbl_keys[pos],
                                          tbl_pays[pos], 1'b1));
                else if (tbl_count >= CAPACITY)
                    step_res.push_back(mk(STAT_FULL, 1'b0, pos, '0, '0, 1'b1));
                else
                begin
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_pays[i] = tbl_pays[i-1];
                    end
                    tbl_keys[pos] = k;
                    tbl_pays[pos] = p;
                    tbl_count++;
                    step_res.push_back(mk(STAT_OK, 1'b0, pos, k, p, 1'b1));
                end
            end
            CMD_FIND:
            begin
                pos = key_position(k, hit);
                if (hit)
                    step_res.push_back(mk(STAT_OK, 1'b1, pos, tbl_keys[pos],
                                          tbl_pays[pos], 1'b1));
                else
                    step_res.push_back(mk(STAT_OK, 1'b0, pos, '0, '0, 1'b1));
            end
            CMD_SCAN:
            begin
                if (tbl_count == 0)
                    step_res.push_back(mk(STAT_EMPTY, 1'b0, 0, '0, '0, 1'b1));
                else
                    for (int i = 0; i < tbl_count; i++)
                        step_res.push_back(mk(STAT_OK, 1'b0, i, tbl_keys[i], tbl_pays[i],
                                              logic'(i + 1 == tbl_count)));
            end
            default: ;
        endcase
    endtask

    task automatic add_row(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        stim_row_t r;
        r.cmd     = c;
        r.key     = k;
        r.payload = p;
        r.known   = 1'b0;
        r.res     = '0;
        rows.push_back(r);
    endtask

    task automatic add_known(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p, result_t res);
        stim_row_t r;
        r.cmd     = c;
        r.key     = k;
        r.payload = p;
        r.known   = 1'b1;
        r.res     = res;
        rows.push_back(r);
    endtask

    // hold the transaction until the table takes it, then book its results
    task automatic offer(input stim_row_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {r.payload, r.key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        table_step(r.cmd, r.key, r.payload);
        if (r.known)
            expected_q.push_back(r.res);
        else
            foreach (step_res[i])
                expected_q.push_back(step_res[i]);
        n_items++;
        if (r.cmd == CMD_SCAN)
            n_scans++;
        if (r.cmd == CMD_NONE)
            n_ignored++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        case ($urandom_range(0, 5))
            0, 1:    if (tbl_count > 0) k = tbl_keys[$urandom_range(0, tbl_count - 1)];
            2:       if (tbl_count > 0) k = tbl_keys[$urandom_range(0, tbl_count - 1)]
                                            + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
            3:       k = $urandom_range(0, 3) == 0 ? '1 : ($urandom_range(0, 1) ? '0 : k);
            default: ;
        endcase
        return k;
    endfunction

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin : drain
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 48);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1'b1;
                end
                else
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= logic'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 4) == 0);
                        default: m_tready <= ~m_tready;
                    endcase
            end
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready)
            begin
                got.slot    = m_tdata[4:0];
                got.key     = m_tdata[36:5];
                got.payload = m_tdata[100:37];
                got.status  = status_t'(m_tuser[1:0]);
                got.found   = m_tuser[2];
                got.last    = m_tlast;
                if (expected_q.size() == 0)
                begin
                    unexpected++;
                    if (reports < 10)
                        $display({"[%0t] unexpected result: status %0d found %0b",
                                  " slot %0d key %h pay %h last %0b"},
                                 $time, got.status, got.found, got.slot, got.key,
                                 got.payload, got.last);
                    reports++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (reports < 10)
                        begin
                            $display("[%0t] mismatch on result %0d", $time, checked);
                            $display({"    expected status %0d found %0b slot %0d",
                                      " key %h pay %h last %0b"},
                                     want.status, want.found, want.slot, want.key,
                                     want.payload, want.last);
                            $display({"    actual   status %0d found %0b slot %0d",
                                      " key %h pay %h last %0b"},
                                     got.status, got.found, got.slot, got.key,
                                     got.payload, got.last);
                        end
                        reports++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_q.size());
                $display("** sorted_key_table: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t r;
        int        real_items;
        int        burst;
        int        sel;
        int        errors;

        // empty table, ignored code, extremes of key and payload
        add_known(CMD_SCAN, 32'h0, 64'h0, mk(STAT_EMPTY, 1'b0, 0, '0, '0, 1'b1));
        add_known(CMD_FIND, 32'h0000_1234, 64'h0, mk(STAT_OK, 1'b0, 0, '0, '0, 1'b1));
        add_row(CMD_NONE, 32'hDEAD_BEEF, 64'hFFFF_0000_FFFF_0000);
        add_known(CMD_INSERT, 32'h8000_0000, 64'h0123_4567_89AB_CDEF,
                  mk(STAT_OK, 1'b0, 0, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 1'b1));
        add_known(CMD_INSERT, 32'h0, '1, mk(STAT_OK, 1'b0, 0, 32'h0, '1, 1'b1));
        add_known(CMD_INSERT, '1, 64'h0, mk(STAT_OK, 1'b0, 2, '1, 64'h0, 1'b1));
        // duplicate keeps the stored payload
        add_known(CMD_INSERT, 32'h0, 64'h5555_5555_5555_5555,
                  mk(STAT_DUP, 1'b1, 0, 32'h0, '1, 1'b1));
        add_known(CMD_FIND, '1, 64'h0, mk(STAT_OK, 1'b1, 2, '1, 64'h0, 1'b1));
        add_known(CMD_FIND, 32'h7FFF_FFFF, 64'h0, mk(STAT_OK, 1'b0, 1, '0, '0, 1'b1));
        add_row(CMD_SCAN, 32'h0, 64'h0);
        // fill in scattered order so entries move at every position
        for (int i = 1; i <= CAPACITY - 3; i++)
            add_row(CMD_INSERT, 32'(i * 32'h9E37_79B9),
                    {~32'(i * 32'h9E37_79B9), 32'(i * 32'h9E37_79B9)});
        add_row(CMD_INSERT, 32'h4000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        add_known(CMD_INSERT, '1, 64'h1, mk(STAT_DUP, 1'b1, CAPACITY - 1, '1, 64'h0, 1'b1));
        add_known(CMD_FIND, 32'h0, 64'h0, mk(STAT_OK, 1'b1, 0, 32'h0, '1, 1'b1));
        add_row(CMD_SCAN, 32'h0, 64'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            offer(rows[i]);
            if ($urandom_range(0, 3) == 0)
                idle_gap();
        end

        // random traffic; the receiver takes its long hold-off while this runs
        hold_req   = 1'b1;
        real_items = 0;
        while (real_items < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                sel       = $urandom_range(0, 19);
                r.known   = 1'b0;
                r.res     = '0;
                r.key     = pick_key();
                r.payload = {$urandom, $urandom};
                if (sel < 7)
                    r.cmd = CMD_INSERT;
                else if (sel < 14)
                    r.cmd = CMD_FIND;
                else if (sel < 18)
                    r.cmd = CMD_SCAN;
                else
                    r.cmd = CMD_NONE;
                offer(r);
                real_items++;
            end
            idle_gap();
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        errors = mismatches + unexpected + expected_q.size();
        $display("Run covered %0d commands (%0d scans, %0d ignored codes), %0d results checked,",
                 n_items, n_scans, n_ignored, checked);
        $display("a %0d-cycle receiver hold-off, %0d mismatches, %0d unexpected results",
                 HOLD_CYCLES, mismatches, unexpected);
        if (errors == 0)
            $display("** sorted_key_table: PASSED **");
        else
            $display("** sorted_key_table: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table.sv
sim/sorted_key_table_tb.sv
